### rtl/sbts_pkg.sv
// ----------------------------------------------------------------------------
// sbts_pkg
// Types, constants and helper functions for the serial beacon track scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbts_pkg;

  localparam int unsigned TrackEntriesDef = 64;
  localparam int unsigned UuidSlotsDef    = 4;

  localparam int unsigned InDataW  = 176;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned CfgDataW = 22;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [15:0] SerialUuidA = 16'hFFE0;
  localparam logic [15:0] SerialUuidB = 16'hFFF0;
  localparam logic [31:0] FnvPrime    = 32'd16777619;
  localparam logic [31:0] FnvBasis    = 32'd2166136261;
  localparam int unsigned PrefixLen   = 19;
  localparam logic [8*PrefixLen-1:0] HashPrefix = "ble:serial-skimmer:";
  localparam logic [7:0] CharColon = 8'h3A;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLOSE_RSSI    = 3'd0,
    REG_DEDUP_WIN     = 3'd1,
    REG_STALE_MS      = 3'd2,
    REG_PERSIST_COUNT = 3'd3,
    REG_PERSIST_MS    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_UPD,
    ST_SCORE,
    ST_HASH,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_COLON,
    PH_HI,
    PH_LO
  } hash_phase_e;

  // flags: bit0 generic, bit1 trusted, bit2 badge, bit3 connectable,
  // bit4 alerted, bits 7..5 max distinct uuid count
  typedef struct packed {
    logic        [47:0] addr;
    logic        [15:0] uuid;
    logic        [47:0] first_ms;
    logic        [47:0] last_ms;
    logic        [15:0] count;
    logic        [31:0] order;
    logic signed [7:0]  best_rssi;
    logic        [7:0]  flags;
  } track_entry_t;

  localparam int unsigned FlGen   = 0;
  localparam int unsigned FlTrust = 1;
  localparam int unsigned FlBadge = 2;
  localparam int unsigned FlConn  = 3;
  localparam int unsigned FlAlert = 4;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] c);
    return (h ^ {24'd0, c}) * FnvPrime;
  endfunction

  function automatic logic [31:0] prefix_hash();
    logic [31:0] h;
    h = FnvBasis;
    for (int i = 0; i < PrefixLen; i++) begin
      h = fnv_step(h, HashPrefix[8*(PrefixLen-1-i) +: 8]);
    end
    return h;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

endpackage

`default_nettype wire

### rtl/serial_beacon_track_scorer_core.sv
// Sequence: accept, then a scan that reads and evaluates each table entry in turn, then
// update, score and MAC hash, then the result; a dropped repeat skips scoring, an item
// without a serial uuid skips update and scoring, and only an alert runs the hash.
// One item at a time: no new item is accepted until the result is taken.
// Reset: async active low; clears valid bits, insertion order, previous time, the
// sequencer and restores register defaults. Table memory is not cleared.
// ----------------------------------------------------------------------------
// serial_beacon_track_scorer_core
// Track table scan, update, scoring and MAC hash under one small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_beacon_track_scorer_core
  import sbts_pkg::*;
#(
  parameter int unsigned TRACK_ENTRIES = TrackEntriesDef,
  parameter int unsigned UUID_SLOTS    = UuidSlotsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // time_ms[47:0] mac[95:48] rssi[103:96] uuid_a[119:104] uuid_b[135:120]
  // uuid_c[151:136] uuid_d[167:152] uuid_count[170:168] generic_name[171]
  // badge_name[172] trusted_flag[173] connectable[174] zero[175]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // alert[0] mac_hash[32:1] seen_count[48:33] serial_uuid[64:49]
  // ev_bits[71:65] best_rssi[79:72] evidence_total[82:80] zero[87:83]
  output logic [OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(TRACK_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TRACK_ENTRIES - 1);
  localparam logic [31:0] PrefixHash = prefix_hash();

  // configuration
  logic signed [7:0] close_q;
  logic [15:0]       dedupe_q;
  logic [21:0]       stale_q;
  logic [15:0]       pcount_q;
  logic [21:0]       pms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_q  <= -8'sd70;
      dedupe_q <= 16'd250;
      stale_q  <= 22'd20000;
      pcount_q <= 16'd3;
      pms_q    <= 22'd5000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLOSE_RSSI:    close_q  <= cfg_data_i[7:0];
        REG_DEDUP_WIN:     dedupe_q <= cfg_data_i[15:0];
        REG_STALE_MS:      stale_q  <= cfg_data_i;
        REG_PERSIST_COUNT: pcount_q <= cfg_data_i[15:0];
        REG_PERSIST_MS:    pms_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input decode
  logic [47:0]       in_time, in_mac;
  logic signed [7:0] in_rssi;
  logic [15:0]       in_uu [4];
  logic [2:0]        in_n;
  logic [2:0]        in_uniq;
  logic              in_has_serial;
  logic [15:0]       in_serial;

  assign in_time  = s_axis_tdata[47:0];
  assign in_mac   = s_axis_tdata[95:48];
  assign in_rssi  = s_axis_tdata[103:96];
  assign in_uu[0] = s_axis_tdata[119:104];
  assign in_uu[1] = s_axis_tdata[135:120];
  assign in_uu[2] = s_axis_tdata[151:136];
  assign in_uu[3] = s_axis_tdata[167:152];
  assign in_n = (s_axis_tdata[170:168] > 3'(UUID_SLOTS)) ? 3'(UUID_SLOTS)
                                                          : s_axis_tdata[170:168];

  always_comb begin
    logic dup;
    in_uniq       = '0;
    in_has_serial = 1'b0;
    in_serial     = '0;
    for (int i = 0; i < 4; i++) begin
      dup = 1'b0;
      for (int j = 0; j < i; j++) begin
        if (in_uu[j] == in_uu[i]) dup = 1'b1;
      end
      if (3'(i) < in_n) begin
        if (!in_has_serial && (in_uu[i] == SerialUuidA || in_uu[i] == SerialUuidB)) begin
          in_has_serial = 1'b1;
          in_serial     = in_uu[i];
        end
        if (!dup) in_uniq = in_uniq + 3'd1;
      end
    end
  end

  // item registers
  logic [47:0]       now_q, mac_q;
  logic signed [7:0] rssi_q;
  logic [2:0]        uniq_q;
  logic              has_serial_q;
  logic [15:0]       serial_q;
  logic [3:0]        iflags_q;   // gen, trust, badge, conn

  // state
  state_e            state_q, state_d;
  logic [TRACK_ENTRIES-1:0] valid_q;
  logic [31:0]       order_cnt_q;
  logic [47:0]       prev_q;
  logic              prev_valid_q;
  logic [IdxW-1:0]   cnt_q;
  logic              hit_f_q, free_f_q, have_pick_q;
  logic [IdxW-1:0]   hit_idx_q, pick_idx_q, wr_idx_q;
  logic [47:0]       pick_last_q;
  logic [31:0]       pick_order_q;
  track_entry_t      ent_q;
  logic [31:0]       hash_q;
  logic [2:0]        byte_q;
  hash_phase_e       phase_q;

  // result
  logic              r_alert_q;
  logic [15:0]       r_count_q, r_uuid_q;
  logic [6:0]        r_mask_q;
  logic [7:0]        r_rssi_q;
  logic [2:0]        r_total_q;

  // track memory
  track_entry_t mem_q [TRACK_ENTRIES];
  track_entry_t rd_q;
  logic         mem_we;
  logic [IdxW-1:0] mem_waddr;
  track_entry_t mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[cnt_q];
  end

  // scan evaluation
  logic        e_valid, e_aged, e_live, e_better;
  logic [47:0] e_age;
  assign e_valid  = valid_q[cnt_q];
  assign e_age    = now_q - rd_q.last_ms;
  assign e_aged   = e_valid && (now_q >= rd_q.last_ms) && (e_age > {26'd0, stale_q});
  assign e_live   = e_valid && !e_aged;
  assign e_better = !have_pick_q || (rd_q.last_ms < pick_last_q) ||
                    ((rd_q.last_ms == pick_last_q) && (rd_q.order < pick_order_q));

  // update
  logic         dedupe_drop;
  track_entry_t upd_ent;
  logic [IdxW-1:0] upd_idx;
  logic [47:0]  since_last;
  assign since_last  = now_q - ent_q.last_ms;
  assign dedupe_drop = hit_f_q &&
                       ((now_q < ent_q.last_ms) || (since_last <= {32'd0, dedupe_q}));

  always_comb begin
    upd_ent = ent_q;
    upd_idx = hit_idx_q;
    if (hit_f_q) begin
      upd_ent.last_ms = now_q;
      if (ent_q.count != 16'hFFFF) upd_ent.count = ent_q.count + 16'd1;
      if (rssi_q > ent_q.best_rssi) upd_ent.best_rssi = rssi_q;
      if (uniq_q > ent_q.flags[7:5]) upd_ent.flags[7:5] = uniq_q;
      upd_ent.flags[3:0] = ent_q.flags[3:0] | iflags_q;
    end else begin
      upd_idx             = pick_idx_q;
      upd_ent.addr        = mac_q;
      upd_ent.uuid        = serial_q;
      upd_ent.first_ms    = now_q;
      upd_ent.last_ms     = now_q;
      upd_ent.count       = 16'd1;
      upd_ent.order       = order_cnt_q;
      upd_ent.best_rssi   = rssi_q;
      upd_ent.flags       = {uniq_q, 1'b0, iflags_q};
    end
  end

  // scoring
  logic [6:0]  ev;
  logic        ev_block, ev_ok;
  logic [47:0] span;
  assign span     = ent_q.last_ms - ent_q.first_ms;
  assign ev_block = ent_q.flags[FlAlert] || ent_q.flags[FlTrust] || ent_q.flags[FlBadge];
  always_comb begin
    ev    = 7'b1000001;
    ev[1] = (ent_q.flags[7:5] == 3'd1);
    ev[2] = ent_q.flags[FlGen];
    ev[3] = (ent_q.count >= pcount_q) && (ent_q.last_ms >= ent_q.first_ms) &&
            (span >= {26'd0, pms_q});
    ev[4] = (ent_q.best_rssi >= close_q);
    ev[5] = ent_q.flags[FlConn];
  end
  assign ev_ok = ev[0] && ev[1] && ev[3] &&
                 ({2'b0, ev[2]} + {2'b0, ev[4]} + {2'b0, ev[5]} + {2'b0, ev[6]} >= 3'd2);

  // hash step
  logic [7:0] h_byte, h_char;
  assign h_byte = ent_q.addr[47 - 8*byte_q -: 8];
  always_comb begin
    unique case (phase_q)
      PH_COLON: h_char = CharColon;
      PH_HI:    h_char = hex_char(h_byte[7:4]);
      PH_LO:    h_char = hex_char(h_byte[3:0]);
      default:  h_char = CharColon;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_RD;
      ST_RD:    state_d = ST_EV;
      ST_EV:    if (cnt_q == LastIdx) state_d = has_serial_q ? ST_UPD : ST_OUT;
                else state_d = ST_RD;
      ST_UPD:   state_d = dedupe_drop ? ST_OUT : ST_SCORE;
      ST_SCORE: state_d = (!ev_block && ev_ok) ? ST_HASH : ST_OUT;
      ST_HASH:  if (byte_q == 3'd5 && phase_q == PH_LO) state_d = ST_OUT;
      ST_OUT:   if (m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign mem_we    = (state_q == ST_UPD && !dedupe_drop) ||
                     (state_q == ST_SCORE && !ev_block && ev_ok);
  assign mem_waddr = (state_q == ST_UPD) ? upd_idx : wr_idx_q;
  always_comb begin
    mem_wdata = (state_q == ST_UPD) ? upd_ent : ent_q;
    if (state_q == ST_SCORE) mem_wdata.flags[FlAlert] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      order_cnt_q  <= '0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      cnt_q        <= '0;
      hit_f_q      <= 1'b0;
      free_f_q     <= 1'b0;
      have_pick_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid) begin
          if (prev_valid_q && in_time < prev_q) begin
            valid_q     <= '0;
            order_cnt_q <= '0;
          end
          prev_q       <= in_time;
          prev_valid_q <= 1'b1;
          cnt_q        <= '0;
          hit_f_q      <= 1'b0;
          free_f_q     <= 1'b0;
          have_pick_q  <= 1'b0;
        end
        ST_EV: begin
          if (e_aged) valid_q[cnt_q] <= 1'b0;
          if (e_live && rd_q.addr == mac_q && !hit_f_q) hit_f_q <= 1'b1;
          if (!free_f_q) begin
            if (!e_live) free_f_q <= 1'b1;
            else if (e_better) have_pick_q <= 1'b1;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        ST_UPD: if (!dedupe_drop && !hit_f_q) begin
          valid_q[pick_idx_q] <= 1'b1;
          if (order_cnt_q != 32'hFFFF_FFFF) order_cnt_q <= order_cnt_q + 32'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        now_q        <= in_time;
        mac_q        <= in_mac;
        rssi_q       <= in_rssi;
        uniq_q       <= in_uniq;
        has_serial_q <= in_has_serial;
        serial_q     <= in_serial;
        iflags_q     <= {s_axis_tdata[174], s_axis_tdata[172], s_axis_tdata[173],
                         s_axis_tdata[171]};
        r_alert_q    <= 1'b0;
        hash_q       <= '0;
        r_count_q    <= '0;
        r_uuid_q     <= '0;
        r_mask_q     <= '0;
        r_rssi_q     <= '0;
        r_total_q    <= '0;
      end
      ST_EV: begin
        if (e_live && rd_q.addr == mac_q && !hit_f_q) begin
          hit_idx_q <= cnt_q;
          ent_q     <= rd_q;
        end
        if (!free_f_q && (!e_live || e_better)) begin
          pick_idx_q   <= cnt_q;
          pick_last_q  <= rd_q.last_ms;
          pick_order_q <= rd_q.order;
        end
      end
      ST_UPD: begin
        ent_q    <= upd_ent;
        wr_idx_q <= upd_idx;
      end
      ST_SCORE: if (!ev_block && ev_ok) begin
        r_alert_q <= 1'b1;
        hash_q    <= PrefixHash;
        byte_q    <= '0;
        phase_q   <= PH_HI;
        r_count_q <= ent_q.count;
        r_uuid_q  <= ent_q.uuid;
        r_mask_q  <= ev;
        r_rssi_q  <= ent_q.best_rssi;
        r_total_q <= 3'($countones(ev));
      end
      ST_HASH: begin
        hash_q <= fnv_step(hash_q, h_char);
        unique case (phase_q)
          PH_COLON: phase_q <= PH_HI;
          PH_HI:    phase_q <= PH_LO;
          PH_LO: begin
            phase_q <= PH_COLON;
            byte_q  <= byte_q + 3'd1;
          end
          default:  phase_q <= PH_HI;
        endcase
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {5'd0, r_total_q, r_rssi_q, r_mask_q, r_uuid_q, r_count_q,
                          hash_q, r_alert_q};

endmodule

`default_nettype wire

### rtl/sbts_checker.sv
// ----------------------------------------------------------------------------
// sbts_checker
// Port-level checks on the track scorer, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module sbts_checker
  import sbts_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
    else $error("not busy after accept");

  a_quiet_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[87:1] == '0))
    else $error("non-alert result not zero");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[82:80]) == $countones(m_axis_tdata[71:65])))
    else $error("evidence total mismatch");

  a_required: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |->
      (m_axis_tdata[65] && m_axis_tdata[66] && m_axis_tdata[68] && m_axis_tdata[71]))
    else $error("alert without required evidence");

endmodule

bind serial_beacon_track_scorer_core sbts_checker u_sbts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
